>>> rtl/neighbor_distance_table_unit_defines.svh
// Assertion macros used by the neighbor distance table top level.
`ifndef NEIGHBOR_DISTANCE_TABLE_UNIT_DEFINES_SVH
`define NEIGHBOR_DISTANCE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define NDTU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ndtu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NDTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ndtu assertion failed");

`else

`define NDTU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NDTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/ndtu_pkg.sv
// Shared types and constants of the neighbor distance table.
package ndtu_pkg;

    // Field widths of the request and result ports.
    localparam int ID_W        = 32;
    localparam int DIST_W      = 16;
    localparam int EIDX_W      = 4;
    localparam int SLOT_W      = 4;
    localparam int COUNT_OUT_W = 5;

    // Internal slot index and count widths cover the largest supported table (256 entries).
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;

    // Command codes.
    localparam logic [2:0] CMD_MERGE  = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_LOOKUP = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // Request data broadcast to every cell during a sweep.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [EIDX_W-1:0] rd_idx;
        logic [CNT_W-1:0]  count;
    } t_query;

    // Entry written into one cell at the end of a request.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_write;

    // Partial search result handed from cell to cell.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  hit_idx;
        logic [DIST_W-1:0] hit_dist;
        logic [IDX_W-1:0]  max_idx;
        logic [DIST_W-1:0] max_dist;
        logic              rd_hit;
        logic [ID_W-1:0]   rd_id;
        logic [DIST_W-1:0] rd_dist;
    } t_carry;

    localparam t_carry CARRY_INIT = '0;

endpackage

>>> rtl/ndtu_cell.sv
// One table entry with its stage of the search chain.
module ndtu_cell import ndtu_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic   i_clk,
    input  t_query i_query,
    input  t_carry i_carry,
    input  logic   i_wr_en,
    input  t_write i_wr,
    output t_carry o_carry
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);

    logic [ID_W-1:0]   r_id;
    logic [DIST_W-1:0] r_dist;
    t_carry            r_carry;
    t_carry            n_carry;
    logic              w_live;

    // The entry holds data only below the fill count.
    assign w_live = (MY_POS < i_query.count);

    // Fold this entry into the partial result from the previous cell.
    always_comb begin
        n_carry = i_carry;
        if (!i_carry.found && w_live && (r_id == i_query.id)) begin
            n_carry.found    = 1'b1;
            n_carry.hit_idx  = MY_IDX;
            n_carry.hit_dist = r_dist;
        end
        // Strict compare keeps the lowest index among equal distances.
        if (i_carry.max_dist < r_dist) begin
            n_carry.max_idx  = MY_IDX;
            n_carry.max_dist = r_dist;
        end
        if (w_live && (MY_POS == CNT_W'(i_query.rd_idx))) begin
            n_carry.rd_hit  = 1'b1;
            n_carry.rd_id   = r_id;
            n_carry.rd_dist = r_dist;
        end
    end

    // Entry storage, written only by the final step of a request.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_id   <= i_wr.id;
            r_dist <= i_wr.distance;
        end
    end

    // Pass the partial result on to the next cell.
    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

endmodule

>>> rtl/neighbor_distance_table_unit.sv
// Top level of the neighbor distance table: control, chain of entry cells and result register.
// Each request is captured, swept through the cells (S_SWEEP), applied (S_WRITE), then strobed.
// No request is taken while one is in flight; the search result moves one cell per cycle.
// A new request may be accepted in the cycle that the previous result is strobed.
// Synchronous active-low reset empties the table (count zero); entry contents are left as they are.
// Each result is strobed for one cycle on o_valid; the receiver cannot stall it.
`include "neighbor_distance_table_unit_defines.svh"

module neighbor_distance_table_unit import ndtu_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic [2:0]             i_command,
    input  logic [ID_W-1:0]        i_neighbor_id,
    input  logic [DIST_W-1:0]      i_distance,
    input  logic [EIDX_W-1:0]      i_entry_index,
    output logic                   busy,
    output logic                   o_valid,
    output logic                   o_found,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [ID_W-1:0]        o_entry_id,
    output logic [DIST_W-1:0]      o_entry_distance,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    localparam int               SWP_W     = $clog2(TABLE_DEPTH + 1);
    localparam logic [SWP_W-1:0] LAST_SWP  = SWP_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state            r_state;
    logic [SWP_W-1:0]  r_swp;
    logic [CNT_W-1:0]  r_count;
    logic [2:0]        r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [DIST_W-1:0] r_dist;
    logic [EIDX_W-1:0] r_idx;

    logic              r_valid;
    logic              r_found;
    logic [SLOT_W-1:0] r_slot;
    logic [ID_W-1:0]   r_eid;
    logic [DIST_W-1:0] r_edist;

    logic              n_found;
    logic [IDX_W-1:0]  n_slot;
    logic [ID_W-1:0]   n_eid;
    logic [DIST_W-1:0] n_edist;
    logic [CNT_W-1:0]  n_count;

    t_query            w_query;
    t_carry            w_chain [TABLE_DEPTH+1];
    t_carry            w_end;
    logic              w_accept;
    logic              w_full;
    logic              w_ins;
    logic [IDX_W-1:0]  w_ins_slot;
    logic [DIST_W:0]   w_sum;
    logic [DIST_W-1:0] w_avg;
    logic              w_do_wr;
    logic [IDX_W-1:0]  w_wr_slot;
    t_write            w_wr;
    logic [TABLE_DEPTH-1:0] w_wr_en;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // Request data seen by every cell.
    assign w_query.id     = r_id;
    assign w_query.rd_idx = r_idx;
    assign w_query.count  = r_count;

    // Chain of entry cells; the search result enters at cell zero.
    assign w_chain[0] = CARRY_INIT;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_wr_en[g] = (r_state == S_WRITE) && w_do_wr && (w_wr_slot == IDX_W'(g));

        ndtu_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_query (w_query),
            .i_carry (w_chain[g]),
            .i_wr_en (w_wr_en[g]),
            .i_wr    (w_wr),
            .o_carry (w_chain[g+1])
        );
    end

    assign w_end = w_chain[TABLE_DEPTH];

    // Insert target and merged distance.
    assign w_full     = (r_count == DEPTH_CNT);
    assign w_ins_slot = w_full ? w_end.max_idx : r_count[IDX_W-1:0];
    assign w_sum      = {1'b0, w_end.hit_dist} + {1'b0, r_dist};
    assign w_avg      = w_sum[DIST_W:1];
    assign w_ins      = ((r_cmd == CMD_MERGE) && !w_end.found) || (r_cmd == CMD_INSERT);

    // Result and table update once the sweep has reached the chain end.
    always_comb begin
        n_found       = 1'b0;
        n_slot        = '0;
        n_eid         = '0;
        n_edist       = '0;
        n_count       = r_count;
        w_do_wr       = 1'b0;
        w_wr_slot     = w_ins_slot;
        w_wr.id       = r_id;
        w_wr.distance = r_dist;
        case (r_cmd)
            CMD_MERGE: begin
                if (w_end.found) begin
                    n_found       = 1'b1;
                    n_slot        = w_end.hit_idx;
                    n_eid         = r_id;
                    n_edist       = w_avg;
                    w_do_wr       = 1'b1;
                    w_wr_slot     = w_end.hit_idx;
                    w_wr.distance = w_avg;
                end
            end
            CMD_LOOKUP: begin
                if (w_end.found) begin
                    n_found = 1'b1;
                    n_slot  = w_end.hit_idx;
                    n_eid   = r_id;
                    n_edist = w_end.hit_dist;
                end
            end
            CMD_READ: begin
                n_slot = IDX_W'(r_idx);
                if (w_end.rd_hit) begin
                    n_eid   = w_end.rd_id;
                    n_edist = w_end.rd_dist;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        // A merge miss and a plain insert share the insert path.
        if (w_ins) begin
            n_slot  = w_ins_slot;
            n_eid   = r_id;
            n_edist = r_dist;
            w_do_wr = 1'b1;
            if (!w_full) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // Control state: sequencer, fill count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_swp   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_WRITE);
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_swp   <= '0;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_swp == LAST_SWP) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_swp <= r_swp + SWP_W'(1);
                    end
                end
                S_WRITE: begin
                    r_count <= n_count;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_id   <= i_neighbor_id;
            r_dist <= i_distance;
            r_idx  <= i_entry_index;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_found <= n_found;
            r_slot  <= n_slot[SLOT_W-1:0];
            r_eid   <= n_eid;
            r_edist <= n_edist;
        end
    end

    assign o_valid          = r_valid;
    assign o_found          = r_found;
    assign o_slot           = r_slot;
    assign o_entry_id       = r_eid;
    assign o_entry_distance = r_edist;
    assign o_entry_count    = r_count[COUNT_OUT_W-1:0];

    // An accepted request always occupies the block in the next cycle.
    `NDTU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy)
    // The final step of a request is always followed by its result strobe.
    `NDTU_ASSERT_NEXT(a_write_strobe, i_clk, i_rst_n, r_state == S_WRITE, o_valid)
    // The fill count never exceeds the table size.
    `NDTU_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_CNT)
    // Only a merge or a lookup can report a match.
    `NDTU_ASSERT_IMPL(a_found_cmd, i_clk, i_rst_n, o_valid && o_found,
        (r_cmd == CMD_MERGE) || (r_cmd == CMD_LOOKUP))
    // At most one entry is written per request.
    `NDTU_ASSERT_IMPL(a_single_write, i_clk, i_rst_n, 1'b1, $onehot0(w_wr_en))

endmodule

>>> dv/tb_neighbor_distance_table_unit.sv
// Self-checking testbench for the neighbor distance table unit.
module tb_neighbor_distance_table_unit import ndtu_pkg::*;;

    localparam int TBL_DEPTH   = 16;
    localparam int RAND_ITEMS  = 1200;
    localparam int POOL_SIZE   = 6;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = TBL_DEPTH + 8;

    // Command codes that the block does not define.
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [2:0]        command;
        logic [ID_W-1:0]   neighbor_id;
        logic [DIST_W-1:0] distance;
        logic [EIDX_W-1:0] entry_index;
    } t_nbr_req;

    typedef struct packed {
        logic                   found;
        logic [SLOT_W-1:0]      slot;
        logic [ID_W-1:0]        entry_id;
        logic [DIST_W-1:0]      entry_distance;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_nbr_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [2:0]             i_command = CMD_MERGE;
    logic [ID_W-1:0]        i_neighbor_id = '0;
    logic [DIST_W-1:0]      i_distance = '0;
    logic [EIDX_W-1:0]      i_entry_index = '0;
    logic                   busy;
    logic                   o_valid;
    logic                   o_found;
    logic [SLOT_W-1:0]      o_slot;
    logic [ID_W-1:0]        o_entry_id;
    logic [DIST_W-1:0]      o_entry_distance;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    // Mirror of the neighbor table.
    logic [ID_W-1:0]        tbl_id [TBL_DEPTH];
    logic [DIST_W-1:0]      tbl_dist [TBL_DEPTH];
    logic [COUNT_OUT_W-1:0] tbl_count = '0;

    t_nbr_req    pending_reqs [$];
    t_nbr_result expected_results [$];
    t_nbr_req    cur_req = '0;
    logic        have_req = 1'b0;
    int          gap_left = 0;
    logic        no_gap_run = 1'b0;
    int          quiet_cycles = 0;
    int          err_count = 0;

    neighbor_distance_table_unit #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_command        (i_command),
        .i_neighbor_id    (i_neighbor_id),
        .i_distance       (i_distance),
        .i_entry_index    (i_entry_index),
        .busy             (busy),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_slot           (o_slot),
        .o_entry_id       (o_entry_id),
        .o_entry_distance (o_entry_distance),
        .o_entry_count    (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Returns the lowest valid slot holding the id, or -1 when absent.
    function automatic int find_id(logic [ID_W-1:0] id);
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (i < tbl_count && tbl_id[i] == id) return i;
        end
        return -1;
    endfunction

    // Appends while there is room; a full table loses its first farthest neighbor.
    function automatic int place_entry(logic [ID_W-1:0] id, logic [DIST_W-1:0] new_dist);
        int target;
        if (tbl_count < TBL_DEPTH) begin
            target = tbl_count;
            tbl_count = tbl_count + 1'b1;
        end else begin
            target = 0;
            for (int i = 1; i < TBL_DEPTH; i++) begin
                if (tbl_dist[target] < tbl_dist[i]) target = i;
            end
        end
        tbl_id[target] = id;
        tbl_dist[target] = new_dist;
        return target;
    endfunction

    // Applies one request to the mirror and returns the result it should produce.
    function automatic t_nbr_result apply_request(t_nbr_req r);
        t_nbr_result res;
        int hit;
        logic [DIST_W:0] dist_sum;
        res = '0;
        case (r.command)
            CMD_MERGE: begin
                hit = find_id(r.neighbor_id);
                if (hit >= 0) begin
                    res.found = 1'b1;
                    res.slot = SLOT_W'(hit);
                    dist_sum = {1'b0, tbl_dist[hit]} + {1'b0, r.distance};
                    tbl_dist[hit] = dist_sum[DIST_W:1];
                end else begin
                    res.slot = SLOT_W'(place_entry(r.neighbor_id, r.distance));
                end
                res.entry_id = tbl_id[res.slot];
                res.entry_distance = tbl_dist[res.slot];
            end
            CMD_INSERT: begin
                res.slot = SLOT_W'(place_entry(r.neighbor_id, r.distance));
                res.entry_id = tbl_id[res.slot];
                res.entry_distance = tbl_dist[res.slot];
            end
            CMD_LOOKUP: begin
                hit = find_id(r.neighbor_id);
                if (hit >= 0) begin
                    res.found = 1'b1;
                    res.slot = SLOT_W'(hit);
                    res.entry_id = tbl_id[hit];
                    res.entry_distance = tbl_dist[hit];
                end
            end
            CMD_READ: begin
                res.slot = r.entry_index;
                if (r.entry_index < tbl_count) begin
                    res.entry_id = tbl_id[r.entry_index];
                    res.entry_distance = tbl_dist[r.entry_index];
                end
            end
            CMD_CLEAR: begin
                tbl_count = '0;
            end
            default: begin
            end
        endcase
        res.entry_count = tbl_count;
        return res;
    endfunction

    task automatic queue_req(logic [2:0] cmd, logic [ID_W-1:0] id, logic [DIST_W-1:0] dist_in,
                             logic [EIDX_W-1:0] idx);
        t_nbr_req r;
        r.command = cmd;
        r.neighbor_id = id;
        r.distance = dist_in;
        r.entry_index = idx;
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(string label, logic [ID_W-1:0] exp_v, logic [ID_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, exp_v, act_v);
            err_count++;
        end
    endtask

    // Request driver: holds each request until the block takes it, then waits a random gap.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_results.push_back(apply_request(cur_req));
            have_req = 1'b0;
            if ($urandom_range(0, 39) == 0) no_gap_run = !no_gap_run;
            gap_left = no_gap_run ? 0 : $urandom_range(0, 6);
        end
        if (i_rst_n && !have_req && pending_reqs.size() != 0) begin
            if (gap_left != 0) begin
                // The gap runs from the moment the block is free again.
                if (!busy) gap_left--;
            end else begin
                cur_req = pending_reqs.pop_front();
                have_req = 1'b1;
            end
        end
        start <= have_req;
        i_command <= cur_req.command;
        i_neighbor_id <= cur_req.neighbor_id;
        i_distance <= cur_req.distance;
        i_entry_index <= cur_req.entry_index;
    end

    // Result monitor: every strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_nbr_result exp_r;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual slot %0h id %0h", $time,
                         o_slot, o_entry_id);
                err_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("found", exp_r.found, o_found);
                check_field("slot", exp_r.slot, o_slot);
                check_field("entry_id", exp_r.entry_id, o_entry_id);
                check_field("entry_distance", exp_r.entry_distance, o_entry_distance);
                check_field("entry_count", exp_r.entry_count, o_entry_count);
            end
        end else if (i_rst_n && $isunknown(o_valid)) begin
            $display("%0t: o_valid unknown, expected 0 or 1, actual %b", $time, o_valid);
            err_count++;
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_neighbor_distance_table_unit: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [ID_W-1:0] id_pool [POOL_SIZE];
        logic [ID_W-1:0] rid;
        logic [DIST_W-1:0] rdist;
        logic [2:0] rcmd;
        int n_rand;
        int ep_len;
        int pick;

        // Directed requests: field extremes, every command and the corner cases.
        queue_req(CMD_READ, '0, '0, 4'hF);                  // read on an empty table
        queue_req(CMD_LOOKUP, '0, '0, '0);                  // lookup on an empty table
        queue_req(CMD_MERGE, '0, '0, '0);                   // merge miss, goes to slot 0
        queue_req(CMD_MERGE, '1, '1, 4'hF);                 // merge miss, goes to slot 1
        queue_req(CMD_MERGE, '1, '1, '0);                   // merge hit, full 17-bit sum
        queue_req(CMD_MERGE, '1, '0, '0);                   // merge hit, floor average
        queue_req(CMD_INSERT, '0, 16'h1234, '0);            // duplicate id by plain insert
        queue_req(CMD_LOOKUP, '0, '0, '0);                  // hit must report the lowest slot
        queue_req(CMD_LOOKUP, 32'h0000_0005, '1, '1);       // lookup miss
        queue_req(CMD_READ, '1, '1, 4'd1);                  // read within the count
        queue_req(CMD_READ, '0, '0, 4'd3);                  // read just past the count
        queue_req(CMD_RSVD_LO, '1, '1, '1);
        queue_req(3'd6, 32'hA5A5_5A5A, 16'h5A5A, 4'hA);
        queue_req(CMD_RSVD_HI, '0, '0, '0);
        queue_req(CMD_CLEAR, '1, '1, '1);
        queue_req(CMD_READ, '0, '0, '0);                    // old contents hidden after clear
        // Fill past full with tied farthest distances.
        for (int k = 0; k < TBL_DEPTH; k++) begin
            queue_req(CMD_INSERT, 32'h1000_0000 + k,
                      (k % 5 == 2) ? 16'hFFFF : DIST_W'(16'h0100 * k), '0);
        end
        queue_req(CMD_INSERT, 32'hDEAD_BEEF, 16'h0001, '0);
        queue_req(CMD_MERGE, 32'hCAFE_F00D, 16'h0002, '0);
        queue_req(CMD_CLEAR, '0, '0, '0);

        // Random episodes over a small set of neighbors so that hits and full tables are common.
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = $urandom;
            ep_len = $urandom_range(20, 80);
            for (int n = 0; n < ep_len; n++) begin
                rid = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                  : $urandom;
                case ($urandom_range(0, 3))
                    0: rdist = '1;
                    1: rdist = DIST_W'($urandom_range(0, 7));
                    default: rdist = DIST_W'($urandom_range(0, 65535));
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 35) rcmd = CMD_MERGE;
                else if (pick < 55) rcmd = CMD_INSERT;
                else if (pick < 75) rcmd = CMD_LOOKUP;
                else if (pick < 92) rcmd = CMD_READ;
                else if (pick < 98) rcmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
                else rcmd = CMD_CLEAR;
                queue_req(rcmd, rid, rdist, EIDX_W'($urandom_range(0, 15)));
            end
            queue_req(CMD_CLEAR, $urandom, DIST_W'($urandom), EIDX_W'($urandom));
            n_rand += ep_len + 1;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || have_req || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("tb_neighbor_distance_table_unit: clean");
        end else begin
            $display("tb_neighbor_distance_table_unit: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ndtu_pkg.sv
rtl/ndtu_cell.sv
rtl/neighbor_distance_table_unit.sv
dv/tb_neighbor_distance_table_unit.sv
